[hdl/bsr_pkg.sv]
// Shared types and constants for the bad-sector remap and CHS translation block.
// No dependencies; used by bsr_div and bad_sector_remap_chs_top.
`default_nettype none

package bsr_pkg;

    localparam int ALT_ENTRIES = 64;
    localparam int IDX_W       = $clog2(ALT_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [1:0] OP_WR_TRACK  = 2'd0;
    localparam logic [1:0] OP_WR_SECTOR = 2'd1;
    localparam logic [1:0] OP_TRANSLATE = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TRACK  = 2'd1;
    localparam logic [1:0] KIND_SECTOR = 2'd2;

    localparam logic [2:0] REG_SPT          = 3'd0;
    localparam logic [2:0] REG_HEADS        = 3'd1;
    localparam logic [2:0] REG_REMAP_EN     = 3'd2;
    localparam logic [2:0] REG_TRK_BASE     = 3'd3;
    localparam logic [2:0] REG_TRK_USED     = 3'd4;
    localparam logic [2:0] REG_SEC_BASE     = 3'd5;
    localparam logic [2:0] REG_SEC_USED     = 3'd6;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[hdl/bad_sector_remap_chs_top.sv]
// Top level: configuration registers, bad-track and bad-sector tables, scan sequencer.
// Depends on bsr_pkg and bsr_div.
`default_nettype none

// Raise start while busy is low to issue a request. Table writes (op 0 and 1)
// finish at the accepting edge and keep busy low. A translate request holds busy
// high while one shared divider and, with remapping on, a table scan do the work
// (the track table is read one entry at a time until a match or the used count,
// and the sector table likewise only when no track entry matched). The result
// appears on the output ports for exactly one cycle with done high; the receiver
// cannot stall it, and the result ports are valid only while done is high.
module bad_sector_remap_chs_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [5:0]  entry_index,
    input  wire logic [31:0] entry_value,
    input  wire logic [31:0] logical_sector,
    output logic             done,
    output logic [31:0]      physical_sector,
    output logic [31:0]      cylinder,
    output logic [7:0]       head,
    output logic [7:0]       sector_in_track,
    output logic [1:0]       remap_kind
);

    localparam int CW = bsr_pkg::CNT_W;
    localparam int IW = bsr_pkg::IDX_W;
    localparam logic [CW-1:0] ENTRIES = CW'(bsr_pkg::ALT_ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_TRK, ST_T_RD, ST_T_CMP, ST_S_RD, ST_S_CMP, ST_DIV_CYL, ST_DIV_HEAD
    } state_t;

    logic [7:0]  spt_cfg_reg;
    logic [8:0]  heads_cfg_reg;
    logic        remap_en_reg;
    logic [31:0] trk_base_reg;
    logic [6:0]  trk_used_reg;
    logic [31:0] sec_base_reg;
    logic [6:0]  sec_used_reg;

    logic [31:0] trk_mem [bsr_pkg::ALT_ENTRIES];
    logic [31:0] sec_mem [bsr_pkg::ALT_ENTRIES];
    logic [31:0] trk_rd_reg;
    logic [31:0] sec_rd_reg;

    state_t      state_reg;
    logic        done_reg;
    logic        div_start_reg;
    logic [31:0] div_dvd_reg;
    logic [15:0] div_dsr_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_trk_reg;
    logic [CW-1:0] n_sec_reg;
    logic [31:0] lsec_reg;
    logic [7:0]  spt_reg;
    logic [15:0] spc_reg;
    logic [31:0] q_trk_reg;
    logic [7:0]  r_trk_reg;
    logic [31:0] phys_reg;
    logic [31:0] cyl_reg;
    logic [7:0]  head_reg;
    logic [7:0]  sit_reg;
    logic [1:0]  kind_reg;

    logic [7:0]  spt_eff;
    logic [8:0]  heads_eff;
    logic [15:0] spc_eff;
    logic [CW-1:0] n_trk_eff;
    logic [CW-1:0] n_sec_eff;
    logic [31:0] trk_phys;
    logic [31:0] sec_phys;
    logic        accept;

    bsr_pkg::div_req_t div_req;
    bsr_pkg::div_rsp_t div_rsp;

    always_comb
    begin
        spt_eff   = (spt_cfg_reg == 8'd0) ? 8'd1 : spt_cfg_reg;
        heads_eff = (heads_cfg_reg == 9'd0) ? 9'd1 :
                    (heads_cfg_reg > 9'd256) ? 9'd256 : heads_cfg_reg;
        spc_eff   = 16'({8'd0, spt_eff} * {7'd0, heads_eff});
        n_trk_eff = (trk_used_reg > 7'(ENTRIES)) ? ENTRIES : CW'(trk_used_reg);
        n_sec_eff = (sec_used_reg > 7'(ENTRIES)) ? ENTRIES : CW'(sec_used_reg);
        trk_phys  = trk_base_reg + 32'(14'(idx_reg[IW-1:0]) * 14'(spt_reg))
                    + {24'd0, r_trk_reg};
        sec_phys  = sec_base_reg + {{(32-IW){1'b0}}, idx_reg[IW-1:0]};
        accept    = start && (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_cfg_reg   <= 8'd63;
            heads_cfg_reg <= 9'd16;
            remap_en_reg  <= 1'b0;
            trk_base_reg  <= '0;
            trk_used_reg  <= '0;
            sec_base_reg  <= '0;
            sec_used_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsr_pkg::REG_SPT:      spt_cfg_reg   <= cfg_data[7:0];
                bsr_pkg::REG_HEADS:    heads_cfg_reg <= cfg_data[8:0];
                bsr_pkg::REG_REMAP_EN: remap_en_reg  <= cfg_data[0];
                bsr_pkg::REG_TRK_BASE: trk_base_reg  <= cfg_data;
                bsr_pkg::REG_TRK_USED: trk_used_reg  <= cfg_data[6:0];
                bsr_pkg::REG_SEC_BASE: sec_base_reg  <= cfg_data;
                bsr_pkg::REG_SEC_USED: sec_used_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == bsr_pkg::OP_WR_TRACK)
        begin
            trk_mem[entry_index] <= entry_value;
        end
        if (accept && op == bsr_pkg::OP_WR_SECTOR)
        begin
            sec_mem[entry_index] <= entry_value;
        end
        trk_rd_reg <= trk_mem[idx_reg[IW-1:0]];
        sec_rd_reg <= sec_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op == bsr_pkg::OP_TRANSLATE)
                    begin
                        lsec_reg      <= logical_sector;
                        spt_reg       <= spt_eff;
                        spc_reg       <= spc_eff;
                        n_trk_reg     <= n_trk_eff;
                        n_sec_reg     <= n_sec_eff;
                        phys_reg      <= logical_sector;
                        kind_reg      <= bsr_pkg::KIND_NONE;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= logical_sector;
                        if (remap_en_reg)
                        begin
                            div_dsr_reg <= {8'd0, spt_eff};
                            state_reg   <= ST_DIV_TRK;
                        end
                        else
                        begin
                            div_dsr_reg <= spc_eff;
                            state_reg   <= ST_DIV_CYL;
                        end
                    end
                end
                ST_DIV_TRK:
                begin
                    if (div_rsp.done)
                    begin
                        q_trk_reg <= div_rsp.quotient;
                        r_trk_reg <= div_rsp.remainder[7:0];
                        idx_reg   <= '0;
                        state_reg <= ST_T_RD;
                    end
                end
                ST_T_RD:
                begin
                    if (idx_reg >= n_trk_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_S_RD;
                    end
                    else
                    begin
                        state_reg <= ST_T_CMP;
                    end
                end
                ST_T_CMP:
                begin
                    if (trk_rd_reg == q_trk_reg)
                    begin
                        phys_reg      <= trk_phys;
                        kind_reg      <= bsr_pkg::KIND_TRACK;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= trk_phys;
                        div_dsr_reg   <= spc_reg;
                        state_reg     <= ST_DIV_CYL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_T_RD;
                    end
                end
                ST_S_RD:
                begin
                    if (idx_reg >= n_sec_reg)
                    begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= lsec_reg;
                        div_dsr_reg   <= spc_reg;
                        state_reg     <= ST_DIV_CYL;
                    end
                    else
                    begin
                        state_reg <= ST_S_CMP;
                    end
                end
                ST_S_CMP:
                begin
                    if (sec_rd_reg == lsec_reg)
                    begin
                        phys_reg      <= sec_phys;
                        kind_reg      <= bsr_pkg::KIND_SECTOR;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= sec_phys;
                        div_dsr_reg   <= spc_reg;
                        state_reg     <= ST_DIV_CYL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_S_RD;
                    end
                end
                ST_DIV_CYL:
                begin
                    if (div_rsp.done)
                    begin
                        cyl_reg       <= div_rsp.quotient;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= {16'd0, div_rsp.remainder};
                        div_dsr_reg   <= {8'd0, spt_reg};
                        state_reg     <= ST_DIV_HEAD;
                    end
                end
                ST_DIV_HEAD:
                begin
                    if (div_rsp.done)
                    begin
                        head_reg  <= div_rsp.quotient[7:0];
                        sit_reg   <= div_rsp.remainder[7:0];
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dvd_reg;
    assign div_req.divisor  = div_dsr_reg;

    bsr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign physical_sector = phys_reg;
    assign cylinder        = cyl_reg;
    assign head            = head_reg;
    assign sector_in_track = sit_reg;
    assign remap_kind      = kind_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer active");
    a_translate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == bsr_pkg::OP_TRANSLATE) |=> busy)
        else $error("translate request did not start sequencer");
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op != bsr_pkg::OP_TRANSLATE) |=> (!busy && !done))
        else $error("table write request started sequencer");
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (remap_kind == bsr_pkg::KIND_NONE || remap_kind == bsr_pkg::KIND_TRACK
                  || remap_kind == bsr_pkg::KIND_SECTOR))
        else $error("bad remap kind");
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sector_in_track < spt_reg))
        else $error("sector within track out of range");
`endif

endmodule

`default_nettype wire

[hdl/bsr_div.sv]
// Iterative restoring divider, 32-bit dividend by nonzero 16-bit divisor, one bit a cycle.
// Depends on bsr_pkg for the request and response structs.
`default_nettype none

module bsr_div
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bsr_pkg::div_req_t req,
    output bsr_pkg::div_rsp_t    rsp
);

    logic        running_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;

    logic [16:0] trial;
    logic        qbit;
    logic [15:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        qbit     = (trial >= {1'b0, dsr_reg});
        rem_next = qbit ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (running_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[tb/bad_sector_remap_chs_top_test.sv]
// Testbench for bad_sector_remap_chs_top: table loads, geometry setups and sector translations.
// Predicts each translation with its own scoreboard class; needs bsr_pkg and the block's RTL.
`default_nettype none

module bad_sector_remap_chs_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2_500_000;
    localparam int unsigned RAND_PHASES = 12;
    localparam int unsigned PHASE_ITEMS = 100;

    typedef struct packed {
        logic [31:0] physical_sector;
        logic [31:0] cylinder;
        logic [7:0]  head;
        logic [7:0]  sector_in_track;
        logic [1:0]  remap_kind;
    } chs_result_t;

    class remap_scoreboard;
        bit [7:0]    spt_reg;
        bit [8:0]    heads_reg;
        bit          remap_reg;
        bit [31:0]   track_base;
        bit [6:0]    track_used;
        bit [31:0]   sector_base;
        bit [6:0]    sector_used;
        bit [31:0]   track_tbl [bsr_pkg::ALT_ENTRIES];
        bit [31:0]   sector_tbl [bsr_pkg::ALT_ENTRIES];
        chs_result_t expected_q [$];
        int unsigned errors;

        function new();
            spt_reg     = 8'd63;
            heads_reg   = 9'd16;
            remap_reg   = 1'b0;
            track_base  = '0;
            track_used  = '0;
            sector_base = '0;
            sector_used = '0;
            errors      = 0;
            foreach (track_tbl[i]) begin
                track_tbl[i]  = '0;
                sector_tbl[i] = '0;
            end
        endfunction

        function void set_reg(logic [2:0] index, logic [31:0] data);
            case (index)
                bsr_pkg::REG_SPT:      spt_reg     = data[7:0];
                bsr_pkg::REG_HEADS:    heads_reg   = data[8:0];
                bsr_pkg::REG_REMAP_EN: remap_reg   = data[0];
                bsr_pkg::REG_TRK_BASE: track_base  = data;
                bsr_pkg::REG_TRK_USED: track_used  = data[6:0];
                bsr_pkg::REG_SEC_BASE: sector_base = data;
                bsr_pkg::REG_SEC_USED: sector_used = data[6:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] eff_spt();
            return (spt_reg == 0) ? 32'd1 : 32'(spt_reg);
        endfunction

        function bit [31:0] eff_heads();
            if (heads_reg == 0)
                return 32'd1;
            return (heads_reg > 9'd256) ? 32'd256 : 32'(heads_reg);
        endfunction

        function int unsigned eff_used(bit [6:0] n);
            return (n > bsr_pkg::ALT_ENTRIES) ? bsr_pkg::ALT_ENTRIES : int'(n);
        endfunction

        function chs_result_t translate(bit [31:0] lsec);
            chs_result_t r;
            bit [31:0]   spt;
            bit [31:0]   spc;
            bit          hit;
            r.physical_sector = lsec;
            r.remap_kind      = bsr_pkg::KIND_NONE;
            hit               = 1'b0;
            spt               = eff_spt();
            spc               = spt * eff_heads();
            if (remap_reg) begin
                for (int unsigned i = 0; i < eff_used(track_used) && !hit; i++) begin
                    if (lsec / spt == track_tbl[i]) begin
                        r.physical_sector = track_base + i * spt + lsec % spt;
                        r.remap_kind      = bsr_pkg::KIND_TRACK;
                        hit               = 1'b1;
                    end
                end
                for (int unsigned i = 0; i < eff_used(sector_used) && !hit; i++) begin
                    if (lsec == sector_tbl[i]) begin
                        r.physical_sector = sector_base + i;
                        r.remap_kind      = bsr_pkg::KIND_SECTOR;
                        hit               = 1'b1;
                    end
                end
            end
            r.cylinder        = r.physical_sector / spc;
            r.head            = 8'((r.physical_sector % spc) / spt);
            r.sector_in_track = 8'(r.physical_sector % spt);
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [5:0] idx, logic [31:0] val,
                                   logic [31:0] lsec);
            case (op)
                bsr_pkg::OP_WR_TRACK:
                    if (idx < bsr_pkg::ALT_ENTRIES) track_tbl[idx] = val;
                bsr_pkg::OP_WR_SECTOR:
                    if (idx < bsr_pkg::ALT_ENTRIES) sector_tbl[idx] = val;
                bsr_pkg::OP_TRANSLATE: expected_q.push_back(translate(lsec));
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(chs_result_t got);
            chs_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with none pending, physical_sector %h",
                                          got.physical_sector));
                return;
            end
            want = expected_q.pop_front();
            if (got.physical_sector !== want.physical_sector)
                report_mismatch($sformatf("physical_sector %h, want %h",
                                          got.physical_sector, want.physical_sector));
            if (got.cylinder !== want.cylinder)
                report_mismatch($sformatf("cylinder %h, want %h",
                                          got.cylinder, want.cylinder));
            if (got.head !== want.head)
                report_mismatch($sformatf("head %h, want %h", got.head, want.head));
            if (got.sector_in_track !== want.sector_in_track)
                report_mismatch($sformatf("sector_in_track %h, want %h",
                                          got.sector_in_track, want.sector_in_track));
            if (got.remap_kind !== want.remap_kind)
                report_mismatch($sformatf("remap_kind %0d, want %0d",
                                          got.remap_kind, want.remap_kind));
        endtask
    endclass

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [2:0]  cfg_index       = '0;
    logic [31:0] cfg_data        = '0;
    logic        start           = 1'b0;
    logic [1:0]  op              = '0;
    logic [5:0]  entry_index     = '0;
    logic [31:0] entry_value     = '0;
    logic [31:0] logical_sector  = '0;
    logic        busy;
    logic        done;
    logic [31:0] physical_sector;
    logic [31:0] cylinder;
    logic [7:0]  head;
    logic [7:0]  sector_in_track;
    logic [1:0]  remap_kind;

    remap_scoreboard sb = new();
    chs_result_t     seen;
    int unsigned     cycle_count = 0;
    int unsigned     gap_odds    = 0;

    bad_sector_remap_chs_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .entry_index     (entry_index),
        .entry_value     (entry_value),
        .logical_sector  (logical_sector),
        .done            (done),
        .physical_sector (physical_sector),
        .cylinder        (cylinder),
        .head            (head),
        .sector_in_track (sector_in_track),
        .remap_kind      (remap_kind)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen = '{physical_sector, cylinder, head, sector_in_track, remap_kind};
            sb.check_result(seen);
        end
    end

    // hold start high; the caller lowers it only for a gap or while waiting for quiet
    task automatic send_request(input logic [1:0] req_op, input logic [5:0] req_idx,
                                input logic [31:0] req_val, input logic [31:0] req_lsec);
        start          <= 1'b1;
        op             <= req_op;
        entry_index    <= req_idx;
        entry_value    <= req_val;
        logical_sector <= req_lsec;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(req_op, req_idx, req_val, req_lsec);
    endtask

    task automatic translate_sector(input logic [31:0] lsec);
        send_request(bsr_pkg::OP_TRANSLATE, 6'($urandom), $urandom, lsec);
    endtask

    task automatic pause(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            pause($urandom_range(1, 9));
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_geometry(input logic [31:0] spt, input logic [31:0] heads,
                                  input logic [31:0] remap, input logic [31:0] tbase,
                                  input logic [31:0] tused, input logic [31:0] sbase,
                                  input logic [31:0] sused);
        write_reg(bsr_pkg::REG_SPT, spt);
        write_reg(bsr_pkg::REG_HEADS, heads);
        write_reg(bsr_pkg::REG_REMAP_EN, remap);
        write_reg(bsr_pkg::REG_TRK_BASE, tbase);
        write_reg(bsr_pkg::REG_TRK_USED, tused);
        write_reg(bsr_pkg::REG_SEC_BASE, sbase);
        write_reg(bsr_pkg::REG_SEC_USED, sused);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_used();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd64;
            3:       return $urandom_range(65, 127);
            default: return $urandom_range(2, 63);
        endcase
    endfunction

    task automatic random_geometry();
        logic [31:0] spt;
        logic [31:0] heads;
        case ($urandom_range(0, 5))
            0:       spt = 32'd0;
            1:       spt = 32'd1;
            2:       spt = 32'd255;
            3:       spt = 32'd63;
            default: spt = $urandom_range(2, 254);
        endcase
        case ($urandom_range(0, 6))
            0:       heads = 32'd0;
            1:       heads = 32'd1;
            2:       heads = 32'd256;
            3:       heads = $urandom_range(257, 511);
            4:       heads = 32'd16;
            default: heads = $urandom_range(2, 255);
        endcase
        apply_geometry(spt, heads, 32'($urandom_range(0, 4) != 0), pick_base(), pick_used(),
                       pick_base(), pick_used());
    endtask

    function automatic logic [31:0] pick_entry_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return sb.track_tbl[$urandom_range(0, bsr_pkg::ALT_ENTRIES - 1)];
            2:       return sb.sector_tbl[$urandom_range(0, bsr_pkg::ALT_ENTRIES - 1)];
            3:       return sb.track_tbl[$urandom_range(0, 7)] * sb.eff_spt()
                            + $urandom_range(0, sb.eff_spt() - 1);
            default: return $urandom_range(0, 5000);
        endcase
    endfunction

    function automatic int unsigned pick_slot(bit [6:0] used);
        int unsigned n;
        n = sb.eff_used(used);
        return (n == 0 || $urandom_range(0, 4) == 0)
               ? $urandom_range(0, bsr_pkg::ALT_ENTRIES - 1)
               : $urandom_range(0, n - 1);
    endfunction

    function automatic logic [31:0] pick_sector();
        logic [31:0] spt;
        spt = sb.eff_spt();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sb.track_tbl[pick_slot(sb.track_used)] * spt
                               + $urandom_range(0, spt - 1);
            4, 5, 6:    return sb.sector_tbl[pick_slot(sb.sector_used)];
            7:          return $urandom;
            8:          return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default:    return $urandom_range(0, 100000);
        endcase
    endfunction

    task automatic random_request();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            send_request(bsr_pkg::OP_WR_TRACK, 6'($urandom), pick_entry_value(), $urandom);
        else if (roll < 12)
            send_request(bsr_pkg::OP_WR_SECTOR, 6'($urandom), pick_entry_value(), $urandom);
        else if (roll < 16)
            send_request(OP_NOP, 6'($urandom), $urandom, $urandom);
        else
            translate_sector(pick_sector());
    endtask

    task automatic fill_tables();
        logic [31:0] val;
        for (int unsigned i = 0; i < bsr_pkg::ALT_ENTRIES; i++)
        begin
            case (i)
                0:       val = 32'd0;
                1, 2:    val = 32'd5;
                3:       val = 32'd1000;
                4:       val = 32'hFFFF_FFFF;
                5:       val = 32'd68174084;
                default: val = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(6, 5000);
            endcase
            send_request(bsr_pkg::OP_WR_TRACK, 6'(i), val, $urandom);
            maybe_pause();
        end
        for (int unsigned i = 0; i < bsr_pkg::ALT_ENTRIES; i++)
        begin
            case (i)
                0:       val = 32'd7;
                1, 2:    val = 32'd100000;
                3:       val = 32'hFFFF_FFFF;
                default: val = ($urandom_range(0, 7) == 0) ? $urandom
                                                           : $urandom_range(0, 400000);
            endcase
            send_request(bsr_pkg::OP_WR_SECTOR, 6'(i), val, $urandom);
            maybe_pause();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds = 3;
        translate_sector(32'd12345);
        fill_tables();
        wait_quiet();

        apply_geometry(32'd63, 32'd16, 32'd1, 32'h0010_0000, 32'd6, 32'h0020_0000, 32'd4);
        translate_sector(32'd0);
        translate_sector(32'd7);
        maybe_pause();
        translate_sector(32'd5 * 63 + 62);
        translate_sector(32'd1000 * 63);
        translate_sector(32'hFFFF_FFFF);
        maybe_pause();
        translate_sector(32'd100000);
        translate_sector(32'd12345678);
        send_request(OP_NOP, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(bsr_pkg::OP_WR_TRACK, 6'h3F, 32'hFFFF_FFFF, 32'h0);
        send_request(bsr_pkg::OP_WR_SECTOR, 6'h3F, 32'h0, 32'h0);
        wait_quiet();

        apply_geometry(32'd255, 32'd256, 32'd0, 32'h0010_0000, 32'd64, 32'h0020_0000, 32'd64);
        translate_sector(32'hFFFF_FFFF);
        translate_sector(32'd0);
        translate_sector(32'd100000);
        wait_quiet();

        apply_geometry(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd127, 32'hFFFF_FFF0, 32'd127);
        translate_sector(32'd0);
        translate_sector(32'd5);
        translate_sector(32'hFFFF_FFFF);
        translate_sector(32'd7);
        wait_quiet();

        apply_geometry(32'd1, 32'd511, 32'd1, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd1);
        translate_sector(32'd7);
        translate_sector(32'hFFFF_FFFE);
        wait_quiet();

        for (int unsigned phase = 0; phase < RAND_PHASES; phase++)
        begin
            random_geometry();
            case ($urandom_range(0, 3))
                0:       gap_odds = 0;
                1:       gap_odds = 2;
                2:       gap_odds = 4;
                default: gap_odds = 8;
            endcase
            if (phase >= RAND_PHASES - 2)
                gap_odds = 0;
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                random_request();
                maybe_pause();
            end
            wait_quiet();
        end

        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
